/* hw/rtl/bgp_pkg.sv */
// Shared types, constants and helpers of the bitmap grid perimeter unit.
package bgp_pkg;

  // Grid geometry.
  localparam int SIDE = 32;
  localparam int ROW_W = $clog2(SIDE);
  localparam logic [5:0] SIDE_IDX = 6'(SIDE);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SIDE - 1);
  localparam logic [SIDE-1:0] SIDE_MASK = {SIDE{1'b1}};
  // The first and last column of a row.
  localparam logic [SIDE-1:0] EDGE_BITS = {1'b1, {(SIDE-2){1'b0}}, 1'b1};

  // Operation codes on the input channel.
  typedef enum logic [2:0] {
    OP_SET_CELL  = 3'd0,
    OP_READ_CELL = 3'd1,
    OP_WRITE_ROW = 3'd2,
    OP_READ_ROW  = 3'd3,
    OP_FILL      = 3'd4,
    OP_ANY_SET   = 3'd5,
    OP_PERIMETER = 3'd6
  } op_t;

  // Command kinds after classification; range errors get a kind of their own.
  typedef enum logic [2:0] {
    CMD_SET_CELL,
    CMD_READ_CELL,
    CMD_WRITE_ROW,
    CMD_READ_ROW,
    CMD_FILL,
    CMD_ANY_SET,
    CMD_PERIMETER,
    CMD_INDEX_ERROR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic             flag;
    logic [SIDE-1:0]  word;
    logic             outer;
    logic             incb;
  } cmd_t;

  typedef struct packed {
    logic        bit_result;
    logic [31:0] row_result;
    logic [5:0]  row_number;
    logic        index_error;
    logic        last;
  } res_t;

  // Write request into the grid store.
  typedef struct packed {
    logic             en;
    logic             fill;
    logic             val;
    logic [ROW_W-1:0] addr;
    logic [SIDE-1:0]  data;
  } grid_wr_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_PERIM
  } back_state_t;

  // Row as seen by the boundary test: inverted in outer mode.
  function automatic logic [SIDE-1:0] xform_row(input logic [SIDE-1:0] row,
                                                input logic outer);
    return outer ? ~row : row;
  endfunction

endpackage

/* hw/rtl/bgp_front.sv */
// Front end: accepts items, classifies them and queues commands.
module bgp_front import bgp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_operation,
  input  logic [5:0]  in_row_index,
  input  logic [5:0]  in_bit_index,
  input  logic        in_flag_value,
  input  logic [31:0] in_row_word,
  input  logic        in_outer_mode,
  input  logic        in_include_boundary,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t        q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  cmd_t        cls;
  logic        keep;
  logic        row_bad, col_bad;
  logic        push, pop;

  // Classify the incoming item and check its coordinates.
  always_comb begin
    row_bad   = in_row_index >= SIDE_IDX;
    col_bad   = in_bit_index >= SIDE_IDX;
    keep      = 1'b1;
    cls.row   = in_row_index[ROW_W-1:0];
    cls.col   = in_bit_index[ROW_W-1:0];
    cls.flag  = in_flag_value;
    cls.word  = in_row_word;
    cls.outer = in_outer_mode;
    cls.incb  = in_include_boundary;
    cls.kind  = CMD_INDEX_ERROR;
    case (op_t'(in_operation))
      OP_SET_CELL:  cls.kind = (row_bad || col_bad) ? CMD_INDEX_ERROR : CMD_SET_CELL;
      OP_READ_CELL: cls.kind = (row_bad || col_bad) ? CMD_INDEX_ERROR : CMD_READ_CELL;
      OP_WRITE_ROW: cls.kind = row_bad ? CMD_INDEX_ERROR : CMD_WRITE_ROW;
      OP_READ_ROW:  cls.kind = row_bad ? CMD_INDEX_ERROR : CMD_READ_ROW;
      OP_FILL:      cls.kind = CMD_FILL;
      OP_ANY_SET:   cls.kind = CMD_ANY_SET;
      OP_PERIMETER: cls.kind = CMD_PERIMETER;
      default:      keep = 1'b0;
    endcase
  end

  // Two-entry command queue toward the back end.
  assign in_full   = cnt_r == 2'd2;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_push && !in_full && keep;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

/* hw/rtl/bgp_grid.sv */
// Grid store: one row per register, a nonzero flag per row, one read port.
module bgp_grid import bgp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [ROW_W-1:0] rd_addr,
  output logic [SIDE-1:0]  rd_data,
  input  grid_wr_t         wr,
  output logic             any_set
);

  logic [SIDE-1:0] rows_r [SIDE];
  logic [SIDE-1:0] nz_r;

  assign rd_data = rows_r[rd_addr];
  assign any_set = |nz_r;

  // Fill writes every row at once; a row write updates one row and its flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SIDE; i++) begin
        rows_r[i] <= '0;
      end
      nz_r <= '0;
    end else if (wr.fill) begin
      for (int i = 0; i < SIDE; i++) begin
        rows_r[i] <= wr.val ? SIDE_MASK : '0;
      end
      nz_r <= {SIDE{wr.val}};
    end else if (wr.en) begin
      rows_r[wr.addr] <= wr.data;
      nz_r[wr.addr]   <= |wr.data;
    end
  end

endmodule

/* hw/rtl/bgp_back.sv */
// Back end: executes commands against the grid and queues the results.
module bgp_back import bgp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  output logic [ROW_W-1:0] rd_addr,
  input  logic [SIDE-1:0]  rd_data,
  input  logic             any_set,
  output grid_wr_t         wr,
  output logic             out_empty,
  input  logic             out_pop,
  output res_t             out_res
);

  back_state_t      state_r, state_nxt;
  logic [SIDE-1:0]  prev_r, prev_nxt;
  logic [SIDE-1:0]  cur_r, cur_nxt;
  logic [ROW_W-1:0] cnt_r, cnt_nxt;
  logic             outer_r, outer_nxt;
  logic             incb_r, incb_nxt;
  logic [SIDE-1:0]  outside;
  logic [SIDE-1:0]  next_row;
  logic [SIDE-1:0]  ncur, vert, horiz;
  logic [SIDE-1:0]  new_row;
  res_t             res;
  logic             res_push;

  res_t             oq_r [2];
  logic             oq_wr_r, oq_rd_r;
  logic [1:0]       oq_cnt_r;
  logic             oq_full, oq_pop;

  // Perimeter datapath on the three-row window.
  always_comb begin
    outside  = incb_r ? '0 : SIDE_MASK;
    next_row = (cnt_r == ROW_LAST) ? outside : xform_row(rd_data, outer_r);
    ncur     = ~cur_r;
    vert     = ~prev_r | ~next_row;
    horiz    = (ncur << 1) | (ncur >> 1) | (incb_r ? EDGE_BITS : '0);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (cmd_valid && cmd.kind == CMD_PERIMETER) state_nxt = BK_LOAD;
      BK_LOAD:  state_nxt = BK_PERIM;
      BK_PERIM: if (!oq_full && cnt_r == ROW_LAST) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    cmd_pop   = 1'b0;
    rd_addr   = cmd.row;
    wr        = '0;
    wr.addr   = cmd.row;
    wr.val    = cmd.flag;
    res       = '0;
    res.last  = 1'b1;
    res_push  = 1'b0;
    new_row   = rd_data;
    new_row[cmd.col] = cmd.flag;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    outer_nxt = outer_r;
    incb_nxt  = incb_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && cmd.kind == CMD_PERIMETER) begin
          cmd_pop   = 1'b1;
          outer_nxt = cmd.outer;
          incb_nxt  = cmd.incb;
        end else if (cmd_valid && !oq_full) begin
          cmd_pop  = 1'b1;
          res_push = 1'b1;
          case (cmd.kind)
            CMD_SET_CELL: begin
              wr.en          = 1'b1;
              wr.data        = new_row;
              res.bit_result = cmd.flag;
            end
            CMD_READ_CELL: res.bit_result = rd_data[cmd.col];
            CMD_WRITE_ROW: begin
              wr.en   = 1'b1;
              wr.data = cmd.word;
            end
            CMD_READ_ROW: res.row_result = rd_data;
            CMD_FILL: begin
              wr.fill        = 1'b1;
              res.bit_result = cmd.flag;
            end
            CMD_ANY_SET:     res.bit_result = any_set;
            CMD_INDEX_ERROR: res.index_error = 1'b1;
            default:         res_push = 1'b0;
          endcase
        end
      end
      BK_LOAD: begin
        rd_addr  = '0;
        prev_nxt = outside;
        cur_nxt  = xform_row(rd_data, outer_r);
        cnt_nxt  = '0;
      end
      BK_PERIM: begin
        rd_addr = cnt_r + ROW_W'(1);
        if (!oq_full) begin
          res_push       = 1'b1;
          res.row_result = cur_r & (vert | horiz);
          res.row_number = {1'b0, cnt_r};
          res.last       = cnt_r == ROW_LAST;
          prev_nxt       = cur_r;
          cur_nxt        = next_row;
          cnt_nxt        = cnt_r + ROW_W'(1);
        end
      end
      default: begin
        res.last = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r  <= prev_nxt;
    cur_r   <= cur_nxt;
    outer_r <= outer_nxt;
    incb_r  <= incb_nxt;
  end

  // Two-entry result queue; the head drives the result ports.
  assign out_empty = oq_cnt_r == 2'd0;
  assign oq_full   = oq_cnt_r == 2'd2;
  assign oq_pop    = out_pop && !out_empty;
  assign out_res   = oq_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      oq_wr_r  <= res_push ? ~oq_wr_r : oq_wr_r;
      oq_rd_r  <= oq_pop ? ~oq_rd_r : oq_rd_r;
      oq_cnt_r <= oq_cnt_r + {1'b0, res_push} - {1'b0, oq_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq_r[oq_wr_r] <= res;
    end
  end

endmodule

/* hw/rtl/bitmap_grid_perimeter_unit.sv */
// Top level of the bitmap grid perimeter unit.
// Usage:
// The block holds a 32 by 32 bit grid, all zero after reset. Items enter on a
// queue-style port: an item is taken at a clock edge where in_push is high and
// in_full is low. Results leave the same way: the oldest result sits on the
// out_ ports while out_empty is low and is taken when out_pop is high.
// Cell, row, fill and any-set items give one result each; a perimeter item
// gives 32 results, rows 0 to 31, with out_last on the final one. An unused
// operation code gives no result.
// Flow: an item waits in the registered command queue, and its result is
// registered in the result queue before it shows on the ports. Single-result
// items run at one item per cycle while the result queue has room and no
// perimeter item holds the back end. A perimeter item leaves the command queue,
// loads row 0 and then gives its rows in order while the result queue has room,
// since the grid has one read port that the three-row window walks down.
// The front queue and the result queue hold two entries each, so when the
// receiver stalls the back end stops and the front keeps taking items until
// its queue is full. Synchronous reset empties both queues and clears the grid.
module bitmap_grid_perimeter_unit import bgp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_operation,
  input  logic [5:0]  in_row_index,
  input  logic [5:0]  in_bit_index,
  input  logic        in_flag_value,
  input  logic [31:0] in_row_word,
  input  logic        in_outer_mode,
  input  logic        in_include_boundary,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_bit_result,
  output logic [31:0] out_row_result,
  output logic [5:0]  out_row_number,
  output logic        out_index_error,
  output logic        out_last
);

  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;
  logic [ROW_W-1:0] rd_addr;
  logic [SIDE-1:0]  rd_data;
  logic             any_set;
  grid_wr_t         wr;
  res_t             out_res;

  bgp_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_operation        (in_operation),
    .in_row_index        (in_row_index),
    .in_bit_index        (in_bit_index),
    .in_flag_value       (in_flag_value),
    .in_row_word         (in_row_word),
    .in_outer_mode       (in_outer_mode),
    .in_include_boundary (in_include_boundary),
    .cmd_valid           (cmd_valid),
    .cmd                 (cmd),
    .cmd_pop             (cmd_pop)
  );

  bgp_grid u_grid (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr),
    .any_set (any_set)
  );

  bgp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .any_set   (any_set),
    .wr        (wr),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

  // Result fields from the head of the result queue.
  assign out_bit_result  = out_res.bit_result;
  assign out_row_result  = out_res.row_result;
  assign out_row_number  = out_res.row_number;
  assign out_index_error = out_res.index_error;
  assign out_last        = out_res.last;

endmodule

/* hw/rtl/bgp_checker.sv */
// Port-level checker of the bitmap grid perimeter unit and its bind.
module bgp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic        out_bit_result,
  input logic [31:0] out_row_result,
  input logic [5:0]  out_row_number,
  input logic        out_index_error,
  input logic        out_last
);

  // Reset leaves both queues empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A waiting result stays, with its row, row number and last flag stable, until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_row_result) &&
      $stable(out_row_number) && $stable(out_last))
    else $error("waiting result changed");

  // An index error is a lone result with no other content.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_index_error |-> out_last && out_row_result == 32'd0 &&
      out_row_number == 6'd0 && !out_bit_result)
    else $error("malformed index error result");

  // Only perimeter rows before the final one come without last.
  a_stream_shape: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_last |-> out_row_number != 6'd31 && out_row_number[5] == 1'b0 &&
      !out_bit_result && !out_index_error)
    else $error("malformed perimeter row");

  // A push against a full queue must not make the queue look drained.
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_full && in_push && !out_pop |=> in_full || out_empty == 1'b0)
    else $error("full queue lost its contents");

endmodule

bind bitmap_grid_perimeter_unit bgp_checker u_bgp_checker (.*);
